// File: src/dcf_pkg.sv
// dcf_pkg: shared types and constants of the dual channel fir filter
// no dependencies; used by every module in src but dcf_ram

package dcf_pkg;

    // default filter order, taps are ORDER+1
    localparam int ORDER_DEFAULT = 127;

    // field widths
    localparam int SAMPLE_W = 18;
    localparam int COEF_W   = 16;
    localparam int IDX_W    = 7;
    localparam int OUT_W    = 32;
    localparam int FRAC_W   = 15;

    // coefficient store never holds more entries than the index field can reach
    localparam int COEF_MAX_DEPTH = 1 << IDX_W;

    // input word kinds carried in tuser
    localparam logic OP_SAMPLE = 1'b0;
    localparam logic OP_COEF   = 1'b1;

    // sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MAC,
        ST_DRAIN
    } state_t;

    // sequencer to mac unit control
    typedef struct packed {
        logic clear;
        logic issue;
        logic coef_live;
    } mac_ctl_t;

endpackage

// File: src/dcf_ram.sv
// dcf_ram: generic single write port, single read port ram with registered read
// no dependencies

module dcf_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 128
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // write port and registered read port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// File: src/dcf_mac.sv
// dcf_mac: two-lane multiply-accumulate unit shared over all taps, plus scaling
// depends on dcf_pkg

module dcf_mac #(
    parameter int ORDER = dcf_pkg::ORDER_DEFAULT
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  dcf_pkg::mac_ctl_t                   ctl,
    input  logic [dcf_pkg::COEF_W-1:0]          coef_rdata,
    input  logic [2*dcf_pkg::SAMPLE_W-1:0]      line_rdata,
    output logic                                busy,
    output logic [dcf_pkg::OUT_W-1:0]           ir_y,
    output logic [dcf_pkg::OUT_W-1:0]           red_y,
    output logic                                sat
);

    localparam int NTAPS  = ORDER + 1;
    localparam int PROD_W = dcf_pkg::COEF_W + dcf_pkg::SAMPLE_W + 1;
    localparam int ACC_MIN = dcf_pkg::OUT_W + dcf_pkg::FRAC_W + 1;
    localparam int ACC_W  = (PROD_W + $clog2(NTAPS) > ACC_MIN) ?
                            PROD_W + $clog2(NTAPS) : ACC_MIN;
    localparam int SH_W   = ACC_W - dcf_pkg::FRAC_W;

    logic                       rd_v_reg;
    logic                       live_reg;
    logic                       prod_v_reg;
    logic signed [PROD_W-1:0]   prod_ir_reg;
    logic signed [PROD_W-1:0]   prod_red_reg;
    logic signed [ACC_W-1:0]    acc_ir_reg;
    logic signed [ACC_W-1:0]    acc_red_reg;
    logic signed [dcf_pkg::COEF_W-1:0] coef_eff;
    logic signed [dcf_pkg::SAMPLE_W:0] x_ir;
    logic signed [dcf_pkg::SAMPLE_W:0] x_red;
    logic sat_ir;
    logic sat_red;

    // floor shift by the fraction bits, clip to the signed output range
    function automatic logic [dcf_pkg::OUT_W:0] scale_sat(input logic [ACC_W-1:0] acc);
        logic [SH_W-1:0]            sh;
        logic [SH_W-dcf_pkg::OUT_W:0] top;
        logic [dcf_pkg::OUT_W:0]    res;
        sh  = acc[ACC_W-1:dcf_pkg::FRAC_W];
        top = sh[SH_W-1:dcf_pkg::OUT_W-1];
        if ((&top) || !(|top)) begin
            res = {1'b0, sh[dcf_pkg::OUT_W-1:0]};
        end else if (sh[SH_W-1]) begin
            res = {1'b1, 1'b1, {(dcf_pkg::OUT_W-1){1'b0}}};
        end else begin
            res = {1'b1, 1'b0, {(dcf_pkg::OUT_W-1){1'b1}}};
        end
        return res;
    endfunction

    // operands from the ram read stage; unwritten coefficients count as zero
    assign coef_eff = live_reg ? $signed(coef_rdata) : '0;
    assign x_ir     = $signed({1'b0, line_rdata[dcf_pkg::SAMPLE_W-1:0]});
    assign x_red    = $signed({1'b0, line_rdata[2*dcf_pkg::SAMPLE_W-1:dcf_pkg::SAMPLE_W]});

    // read, multiply and accumulate stages
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rd_v_reg   <= 1'b0;
            prod_v_reg <= 1'b0;
        end else begin
            rd_v_reg   <= ctl.issue;
            prod_v_reg <= rd_v_reg;
        end
        live_reg     <= ctl.coef_live;
        prod_ir_reg  <= PROD_W'(coef_eff * x_ir);
        prod_red_reg <= PROD_W'(coef_eff * x_red);
        if (ctl.clear) begin
            acc_ir_reg  <= '0;
            acc_red_reg <= '0;
        end else if (prod_v_reg) begin
            acc_ir_reg  <= acc_ir_reg + ACC_W'(prod_ir_reg);
            acc_red_reg <= acc_red_reg + ACC_W'(prod_red_reg);
        end
    end

    assign busy = rd_v_reg | prod_v_reg;

    // final scaling of both lanes
    always_comb begin
        {sat_ir, ir_y}   = scale_sat(acc_ir_reg);
        {sat_red, red_y} = scale_sat(acc_red_reg);
        sat = sat_ir | sat_red;
    end

endmodule

// File: src/dcf_ctrl.sv
// dcf_ctrl: sequencer for coefficient loads, sample writes and the tap loop
// depends on dcf_pkg

module dcf_ctrl #(
    parameter int ORDER = dcf_pkg::ORDER_DEFAULT
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  logic                                 in_op,
    input  logic [dcf_pkg::IDX_W-1:0]            in_idx,
    input  logic                                 mac_busy,
    input  logic                                 out_free,
    output logic                                 coef_we,
    output logic [$clog2((ORDER + 1 < dcf_pkg::COEF_MAX_DEPTH) ?
                  ORDER + 1 : dcf_pkg::COEF_MAX_DEPTH)-1:0] coef_waddr,
    output logic [$clog2((ORDER + 1 < dcf_pkg::COEF_MAX_DEPTH) ?
                  ORDER + 1 : dcf_pkg::COEF_MAX_DEPTH)-1:0] coef_raddr,
    output logic                                 line_we,
    output logic [$clog2(ORDER + 1)-1:0]         line_waddr,
    output logic [$clog2(ORDER + 1)-1:0]         line_raddr,
    output dcf_pkg::mac_ctl_t                    mac_ctl,
    output logic                                 out_load,
    output logic                                 out_last
);

    localparam int NTAPS  = ORDER + 1;
    localparam int CDEPTH = (NTAPS < dcf_pkg::COEF_MAX_DEPTH) ? NTAPS : dcf_pkg::COEF_MAX_DEPTH;
    localparam int CAW    = $clog2(CDEPTH);
    localparam int PW     = $clog2(NTAPS);
    localparam int FW     = $clog2(NTAPS + 1);
    localparam int BW     = $clog2(ORDER + 1);

    dcf_pkg::state_t state_reg, state_next;
    logic [PW-1:0]   wptr_reg, wptr_next;
    logic [PW-1:0]   rptr_reg, rptr_next;
    logic [PW-1:0]   tap_reg, tap_next;
    logic [FW-1:0]   fill_reg, fill_next;
    logic [BW-1:0]   pos_reg, pos_next;
    logic [CDEPTH-1:0] cvalid_reg, cvalid_next;
    logic            accept;
    logic [PW-1:0]   wptr_inc;
    logic [BW:0]     pos_inc;

    // state and counters
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= dcf_pkg::ST_IDLE;
            wptr_reg   <= '0;
            rptr_reg   <= '0;
            tap_reg    <= '0;
            fill_reg   <= '0;
            pos_reg    <= '0;
            cvalid_reg <= '0;
        end else begin
            state_reg  <= state_next;
            wptr_reg   <= wptr_next;
            rptr_reg   <= rptr_next;
            tap_reg    <= tap_next;
            fill_reg   <= fill_next;
            pos_reg    <= pos_next;
            cvalid_reg <= cvalid_next;
        end
    end

    // next state and outputs
    always_comb begin
        state_next  = state_reg;
        wptr_next   = wptr_reg;
        rptr_next   = rptr_reg;
        tap_next    = tap_reg;
        fill_next   = fill_reg;
        pos_next    = pos_reg;
        cvalid_next = cvalid_reg;

        in_ready    = (state_reg == dcf_pkg::ST_IDLE);
        accept      = in_valid & in_ready;
        coef_we     = 1'b0;
        coef_waddr  = in_idx[CAW-1:0];
        coef_raddr  = tap_reg[CAW-1:0];
        line_we     = 1'b0;
        line_waddr  = wptr_reg;
        line_raddr  = rptr_reg;
        mac_ctl     = '0;
        out_load    = 1'b0;
        out_last    = 1'b0;

        wptr_inc = (wptr_reg == PW'(NTAPS - 1)) ? '0 : wptr_reg + 1'b1;
        pos_inc  = {1'b0, pos_reg} + 1'b1;

        unique case (state_reg)
            dcf_pkg::ST_IDLE: begin
                if (accept && in_op == dcf_pkg::OP_COEF) begin
                    // indexes past the taps are dropped
                    if ({1'b0, in_idx} < (dcf_pkg::IDX_W + 1)'(CDEPTH)) begin
                        coef_we = 1'b1;
                        cvalid_next[in_idx[CAW-1:0]] = 1'b1;
                    end
                end else if (accept) begin
                    line_we = 1'b1;
                    if (fill_reg < FW'(NTAPS)) begin
                        fill_next = fill_reg + 1'b1;
                    end
                    if (fill_reg >= FW'(NTAPS - 1)) begin
                        // line full: run the tap loop from the newest sample
                        state_next    = dcf_pkg::ST_MAC;
                        tap_next      = '0;
                        rptr_next     = wptr_reg;
                        mac_ctl.clear = 1'b1;
                    end else begin
                        wptr_next = wptr_inc;
                    end
                end
            end
            dcf_pkg::ST_MAC: begin
                // one tap per cycle on both lanes
                mac_ctl.issue     = 1'b1;
                mac_ctl.coef_live = ({1'b0, tap_reg} < (PW + 1)'(CDEPTH)) &&
                                    cvalid_reg[tap_reg[CAW-1:0]];
                tap_next  = tap_reg + 1'b1;
                rptr_next = (rptr_reg == '0) ? PW'(NTAPS - 1) : rptr_reg - 1'b1;
                if (tap_reg == PW'(NTAPS - 1)) begin
                    state_next = dcf_pkg::ST_DRAIN;
                end
            end
            dcf_pkg::ST_DRAIN: begin
                // wait for the pipeline to empty and the output slot to free
                if (!mac_busy && out_free) begin
                    out_load   = 1'b1;
                    out_last   = (pos_inc >= (BW + 1)'(ORDER));
                    pos_next   = out_last ? '0 : pos_inc[BW-1:0];
                    wptr_next  = wptr_inc;
                    state_next = dcf_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = dcf_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

// File: src/dual_channel_fir_filter.sv
// dual_channel_fir_filter: top level, two-channel fir with shared coefficients
// depends on dcf_pkg, dcf_ram, dcf_mac, dcf_ctrl
//
// channel   ports       tdata (low bit up)                               tuser / tlast
// input     s_t*        ir_sample, red_sample, coef_index, coef_value    tuser = op
// output    m_t*        ir_filtered, red_filtered                        tlast = block_last,
//                                                                        tuser = saturated
//
// a coefficient word, or a sample word during warm-up, is taken in the idle state; any other
// sample word is written to the delay line, then the shared two-lane multiplier steps
// through all ORDER+1 taps, then the ram read and product stages drain. reset clears
// counters and coefficient valid bits, no clearing pass.
// a stalled output holds the filter in its drain state until the output register frees.

module dual_channel_fir_filter #(
    parameter int ORDER = dcf_pkg::ORDER_DEFAULT
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,   // ir_sample, red_sample, coef_index, coef_value, zero pad
    input  logic        s_tuser,   // op
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata,   // ir_filtered, red_filtered
    output logic        m_tlast,
    output logic        m_tuser    // saturated
);

    localparam int NTAPS  = ORDER + 1;
    localparam int CDEPTH = (NTAPS < dcf_pkg::COEF_MAX_DEPTH) ? NTAPS : dcf_pkg::COEF_MAX_DEPTH;
    localparam int CAW    = $clog2(CDEPTH);
    localparam int PW     = $clog2(NTAPS);
    localparam int LW     = 2 * dcf_pkg::SAMPLE_W;
    localparam int SW     = dcf_pkg::SAMPLE_W;

    logic [SW-1:0]               ir_sample;
    logic [SW-1:0]               red_sample;
    logic [dcf_pkg::IDX_W-1:0]   coef_index;
    logic [dcf_pkg::COEF_W-1:0]  coef_value;

    logic                        coef_we;
    logic [CAW-1:0]              coef_waddr;
    logic [CAW-1:0]              coef_raddr;
    logic [dcf_pkg::COEF_W-1:0]  coef_rdata;
    logic                        line_we;
    logic [PW-1:0]               line_waddr;
    logic [PW-1:0]               line_raddr;
    logic [LW-1:0]               line_rdata;
    dcf_pkg::mac_ctl_t           mac_ctl;
    logic                        mac_busy;
    logic [dcf_pkg::OUT_W-1:0]   ir_y;
    logic [dcf_pkg::OUT_W-1:0]   red_y;
    logic                        sat;
    logic                        out_free;
    logic                        out_load;
    logic                        out_last;

    logic                        m_tvalid_reg;
    logic [63:0]                 m_tdata_reg;
    logic                        m_tlast_reg;
    logic                        m_tuser_reg;

    // unpack input word
    assign ir_sample  = s_tdata[SW-1:0];
    assign red_sample = s_tdata[2*SW-1:SW];
    assign coef_index = s_tdata[2*SW+dcf_pkg::IDX_W-1:2*SW];
    assign coef_value = s_tdata[2*SW+dcf_pkg::IDX_W+dcf_pkg::COEF_W-1:2*SW+dcf_pkg::IDX_W];

    // sequencer
    dcf_ctrl #(.ORDER(ORDER)) u_ctrl (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .in_op      (s_tuser),
        .in_idx     (coef_index),
        .mac_busy   (mac_busy),
        .out_free   (out_free),
        .coef_we    (coef_we),
        .coef_waddr (coef_waddr),
        .coef_raddr (coef_raddr),
        .line_we    (line_we),
        .line_waddr (line_waddr),
        .line_raddr (line_raddr),
        .mac_ctl    (mac_ctl),
        .out_load   (out_load),
        .out_last   (out_last)
    );

    // coefficient store
    dcf_ram #(.WIDTH(dcf_pkg::COEF_W), .DEPTH(CDEPTH)) u_coef_ram (
        .aclk  (aclk),
        .we    (coef_we),
        .waddr (coef_waddr),
        .wdata (coef_value),
        .raddr (coef_raddr),
        .rdata (coef_rdata)
    );

    // circular delay line, both channels side by side
    dcf_ram #(.WIDTH(LW), .DEPTH(NTAPS)) u_line_ram (
        .aclk  (aclk),
        .we    (line_we),
        .waddr (line_waddr),
        .wdata ({red_sample, ir_sample}),
        .raddr (line_raddr),
        .rdata (line_rdata)
    );

    // shared multiply-accumulate unit
    dcf_mac #(.ORDER(ORDER)) u_mac (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .ctl        (mac_ctl),
        .coef_rdata (coef_rdata),
        .line_rdata (line_rdata),
        .busy       (mac_busy),
        .ir_y       (ir_y),
        .red_y      (red_y),
        .sat        (sat)
    );

    // output register
    assign out_free = !m_tvalid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (out_load) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
        if (out_load) begin
            m_tdata_reg <= {red_y, ir_y};
            m_tlast_reg <= out_last;
            m_tuser_reg <= sat;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;
    assign m_tuser  = m_tuser_reg;

endmodule

// File: test/tb_dual_channel_fir_filter.sv
// tb_dual_channel_fir_filter: self-checking bench for the two-channel fir filter
// depends on dcf_pkg and dual_channel_fir_filter; predicts every filtered pair
// from its own copy of the taps and delay lines and checks the m_ stream against it

module tb_dual_channel_fir_filter;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int ORDER       = dcf_pkg::ORDER_DEFAULT;
    localparam int NTAPS       = ORDER + 1;
    localparam int SMP_W       = dcf_pkg::SAMPLE_W;
    localparam int CF_W        = dcf_pkg::COEF_W;
    localparam int IX_W        = dcf_pkg::IDX_W;
    localparam int Y_W         = dcf_pkg::OUT_W;
    localparam int SMP_MAX     = (1 << SMP_W) - 1;
    localparam int STALL_LIMIT = 20 * (ORDER + 5);
    localparam longint Q_HI    = 64'sd2147483647;
    localparam longint Q_LO    = -64'sd2147483648;

    // one input word, plus the pacing hints the driver honors
    typedef struct {
        logic                     op;
        logic [SMP_W-1:0]         ir;
        logic [SMP_W-1:0]         red;
        logic [IX_W-1:0]          idx;
        logic signed [CF_W-1:0]   cval;
        bit                       drain_first;
        bit                       brisk;
    } word_t;

    // one filtered pair as it should leave the block
    typedef struct {
        logic [Y_W-1:0]   ir;
        logic [Y_W-1:0]   red;
        logic             blk_last;
        logic             clipped;
    } pair_t;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [63:0] s_tdata  = '0;    // ir_sample, red_sample, coef_index, coef_value, zero pad
    logic        s_tuser  = dcf_pkg::OP_SAMPLE;  // op
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [63:0] m_tdata;          // ir_filtered, red_filtered
    logic        m_tlast;
    logic        m_tuser;          // saturated

    // predictor state, cleared once like the block after its single reset
    logic signed [CF_W-1:0]   coef_tab [NTAPS] = '{default: '0};
    logic [SMP_W-1:0]         ir_line  [NTAPS] = '{default: '0};
    logic [SMP_W-1:0]         red_line [NTAPS] = '{default: '0};
    int                       held_cnt = 0;
    int                       slot_pos = 0;

    word_t word_q[$];
    pair_t filtered_q[$];
    int    words_taken = 0;
    int    total_words = 0;
    int    err_cnt     = 0;

    // driver and monitor bookkeeping
    word_t cur_word;
    word_t next_word;
    bit    has_next   = 1'b0;
    bit    drv_busy   = 1'b0;
    int    gap_left   = 0;
    int    rx_hold    = 0;
    bit    burst_mode = 1'b0;
    int    idle_cycles = 0;
    pair_t want;

    always #5ns aclk = ~aclk;

    dual_channel_fir_filter #(
        .ORDER(ORDER)
    ) u_top (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tlast (m_tlast),
        .m_tuser (m_tuser)
    );

    // append one word to the pending stimulus
    function automatic void queue_word(input word_t w);
        word_q.insert(word_q.size(), w);
    endfunction

    // floor shift by the fraction bits, then clip to 32 bits; msb flags clipping
    function automatic logic [Y_W:0] scale_clip(input longint acc);
        longint q;
        q = acc >>> dcf_pkg::FRAC_W;
        if (q > Q_HI)
            return {1'b1, Q_HI[Y_W-1:0]};
        if (q < Q_LO)
            return {1'b1, Q_LO[Y_W-1:0]};
        return {1'b0, q[Y_W-1:0]};
    endfunction

    // apply one accepted word to the filter image, queue the pair it yields
    function automatic void filter_word(input word_t w);
        longint         ir_acc;
        longint         red_acc;
        logic [Y_W:0]   ir_s;
        logic [Y_W:0]   red_s;
        pair_t          p;
        if (w.op == dcf_pkg::OP_COEF) begin
            if (w.idx < NTAPS)
                coef_tab[w.idx] = w.cval;
            return;
        end
        for (int k = NTAPS - 1; k > 0; k--) begin
            ir_line[k]  = ir_line[k-1];
            red_line[k] = red_line[k-1];
        end
        ir_line[0]  = w.ir;
        red_line[0] = w.red;
        if (held_cnt < NTAPS)
            held_cnt++;
        if (held_cnt < NTAPS)
            return;
        ir_acc  = 0;
        red_acc = 0;
        for (int k = 0; k < NTAPS; k++) begin
            ir_acc  += longint'(coef_tab[k]) * longint'(ir_line[k]);
            red_acc += longint'(coef_tab[k]) * longint'(red_line[k]);
        end
        ir_s  = scale_clip(ir_acc);
        red_s = scale_clip(red_acc);
        slot_pos++;
        p.blk_last = (slot_pos >= ORDER);
        if (p.blk_last)
            slot_pos = 0;
        p.ir      = ir_s[Y_W-1:0];
        p.red     = red_s[Y_W-1:0];
        p.clipped = ir_s[Y_W] | red_s[Y_W];
        filtered_q.insert(filtered_q.size(), p);
    endfunction

    // sample value leaning toward the rails now and then
    function automatic logic [SMP_W-1:0] rand_sample();
        case ($urandom_range(0, 7))
            0: return '0;
            1: return SMP_MAX[SMP_W-1:0];
            default: return SMP_W'($urandom_range(0, SMP_MAX));
        endcase
    endfunction

    function automatic logic signed [CF_W-1:0] rand_coef();
        case ($urandom_range(0, 7))
            0: return 16'sh7fff;
            1: return 16'sh8000;
            default: return CF_W'($urandom_range(0, 16'hffff));
        endcase
    endfunction

    // sample word; the unused coefficient fields carry noise
    function automatic word_t sample_word(input logic [SMP_W-1:0] ir,
                                          input logic [SMP_W-1:0] red);
        word_t w;
        w.op          = dcf_pkg::OP_SAMPLE;
        w.ir          = ir;
        w.red         = red;
        w.idx         = IX_W'($urandom_range(0, (1 << IX_W) - 1));
        w.cval        = CF_W'($urandom_range(0, 16'hffff));
        w.drain_first = 1'b0;
        w.brisk       = 1'b0;
        return w;
    endfunction

    // coefficient word; the unused sample fields carry noise
    function automatic word_t coef_word(input logic [IX_W-1:0] idx,
                                        input logic signed [CF_W-1:0] val);
        word_t w;
        w.op          = dcf_pkg::OP_COEF;
        w.ir          = SMP_W'($urandom_range(0, SMP_MAX));
        w.red         = SMP_W'($urandom_range(0, SMP_MAX));
        w.idx         = idx;
        w.cval        = val;
        w.drain_first = 1'b0;
        w.brisk       = 1'b0;
        return w;
    endfunction

    // driver: random gap before each word but brisk ones, optional drain of pending pairs
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            has_next = 1'b0;
            drv_busy = 1'b0;
        end else begin
            drv_busy = s_tvalid;
            if (s_tvalid && s_tready) begin
                filter_word(cur_word);
                words_taken++;
                burst_mode <= cur_word.brisk;
                drv_busy = 1'b0;
            end
            if (!drv_busy && !has_next && word_q.size() != 0) begin
                next_word = word_q.pop_front();
                gap_left  = next_word.brisk ? 0 : $urandom_range(0, 3);
                has_next  = 1'b1;
            end
            if (!drv_busy && has_next) begin
                if (gap_left != 0) begin
                    gap_left--;
                end else if (!next_word.drain_first || filtered_q.size() == 0) begin
                    cur_word = next_word;
                    has_next = 1'b0;
                    drv_busy = 1'b1;
                    s_tdata  <= {5'b0, next_word.cval, next_word.idx,
                                 next_word.red, next_word.ir};
                    s_tuser  <= next_word.op;
                end
            end
            s_tvalid <= drv_busy;
        end
    end

    // monitor: stall each result for a random count of valid cycles outside burst mode, check fields
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
            rx_hold = $urandom_range(0, 3);
        end else begin
            if (m_tvalid && m_tready) begin
                if (filtered_q.size() == 0) begin
                    $error("filtered word with no prediction pending");
                    err_cnt++;
                end else begin
                    want = filtered_q.pop_front();
                    if (m_tdata[31:0] !== want.ir) begin
                        $error("ir_filtered: expected %0d, got %0d",
                               $signed(want.ir), $signed(m_tdata[31:0]));
                        err_cnt++;
                    end
                    if (m_tdata[63:32] !== want.red) begin
                        $error("red_filtered: expected %0d, got %0d",
                               $signed(want.red), $signed(m_tdata[63:32]));
                        err_cnt++;
                    end
                    if (m_tlast !== want.blk_last) begin
                        $error("block_last: expected %0b, got %0b", want.blk_last, m_tlast);
                        err_cnt++;
                    end
                    if (m_tuser !== want.clipped) begin
                        $error("saturated: expected %0b, got %0b", want.clipped, m_tuser);
                        err_cnt++;
                    end
                end
                rx_hold = burst_mode ? 0 : $urandom_range(0, 3);
            end else if (m_tvalid && rx_hold != 0) begin
                rx_hold--;
            end
            m_tready <= (rx_hold == 0);
        end
    end

    // watchdog on cycles without any word moving
    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= STALL_LIMIT) begin
                $display("Some tests failed");
                $finish;
            end
        end
    end

    // stimulus and end of run
    initial begin
        word_t w;
        int    n_samp;

        // taps at the rails and alternating bit patterns
        queue_word(coef_word(7'd0,   16'sh7fff));
        queue_word(coef_word(7'd127, 16'sh8000));
        queue_word(coef_word(7'd1,   -16'sd1));
        queue_word(coef_word(7'd2,   16'sd1));
        queue_word(coef_word(7'd126, 16'sh5555));
        queue_word(coef_word(7'd3,   16'shaaaa));
        queue_word(coef_word(7'd64,  16'sd0));
        // coefficient word with sample fields all ones, then all zeros
        w = coef_word(7'd5, 16'sd100);
        w.ir  = '1;
        w.red = '1;
        queue_word(w);
        w = coef_word(7'd6, -16'sd100);
        w.ir  = '0;
        w.red = '0;
        queue_word(w);

        // warm-up samples at the extremes; none of these may yield a pair
        queue_word(sample_word(SMP_MAX[SMP_W-1:0], '0));
        queue_word(sample_word('0, SMP_MAX[SMP_W-1:0]));
        queue_word(sample_word(SMP_MAX[SMP_W-1:0], SMP_MAX[SMP_W-1:0]));
        queue_word(sample_word('0, '0));
        queue_word(sample_word(18'h2aaaa, 18'h15555));
        queue_word(sample_word(18'h15555, 18'h2aaaa));
        // sample words with coefficient fields that must be ignored
        w = sample_word(18'h3ffff, 18'h00001);
        w.idx  = '1;
        w.cval = '1;
        queue_word(w);
        w = sample_word(18'h00001, 18'h3ffff);
        w.idx  = '0;
        w.cval = 16'sh8000;
        queue_word(w);
        n_samp = 8;

        // fill the delay lines up to the first output, then two more pairs
        while (n_samp < NTAPS + 2) begin
            queue_word(sample_word(rand_sample(), rand_sample()));
            n_samp++;
        end

        // tap reload mid-stream, issued once the filter has gone quiet
        w = coef_word(7'd0, 16'sh8000);
        w.drain_first = 1'b1;
        queue_word(w);
        queue_word(sample_word(SMP_MAX[SMP_W-1:0], SMP_MAX[SMP_W-1:0]));

        // random traffic: mostly samples, some tap loads, a burst without idling
        for (int i = 0; i < 310; i++) begin
            if ($urandom_range(0, 4) == 0)
                w = coef_word(IX_W'($urandom_range(0, (1 << IX_W) - 1)), rand_coef());
            else
                w = sample_word(rand_sample(), rand_sample());
            w.drain_first = ($urandom_range(0, 39) == 0);
            w.brisk       = (i >= 150 && i < 210);
            queue_word(w);
        end
        total_words = word_q.size();

        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;

        while (words_taken != total_words)
            @(posedge aclk);
        while (filtered_q.size() != 0)
            @(posedge aclk);
        repeat (ORDER + 20) @(posedge aclk);

        if (err_cnt == 0 && filtered_q.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
